// File: rtl/small_value_set_engine_assert.svh
// Assertion macros shared by the checkers of the value set engine.
// Used by rtl/svs_checker.sv; no other dependencies.
`ifndef SMALL_VALUE_SET_ENGINE_ASSERT_SVH
`define SMALL_VALUE_SET_ENGINE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SVS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("svs check failed");

// antecedent implies consequent in the next cycle
`define SVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("svs check failed");

`endif

// File: rtl/svs_pkg.sv
// Shared types and constants of the value set engine.
// No dependencies; used by every module of the block but svs_ram.
package svs_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int VALUE_BITS_DEF = 32;

   localparam int FUNC_W   = 3;
   localparam int DATA_W   = 32;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   localparam logic [FUNC_W-1:0] OP_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [FUNC_W-1:0] OP_QUERY  = 3'd2;
   localparam logic [FUNC_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [FUNC_W-1:0] OP_SORT   = 3'd4;
   localparam logic [FUNC_W-1:0] OP_READ   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] value;
      logic [INDEX_W-1:0]       index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic                     found;
      logic [POS_W-1:0]         position;
      logic [COUNT_W-1:0]       count;
      logic signed [DATA_W-1:0] element;
   } rsp_type;

endpackage

// File: rtl/svs_ram.sv
// Entry store of the value set engine: one write port, one read port,
// read data registered. No package dependencies.
module svs_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/svs_ctrl.sv
// Sequencer of the value set engine: scan, shift, bubble sort and read
// over the entry store. Depends on svs_pkg; drives svs_ram.
module svs_ctrl #(
   parameter int CAPACITY   = svs_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = svs_pkg::VALUE_BITS_DEF,
   localparam int AW        = $clog2(CAPACITY),
   localparam int CW        = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  svs_pkg::req_type             req_data,
   output logic                         fin_valid,
   input  logic                         fin_take,
   output svs_pkg::rsp_type             fin_data,
   output logic                         wr_en,
   output logic [AW-1:0]                wr_addr,
   output logic signed [VALUE_BITS-1:0] wr_data,
   output logic [AW-1:0]                rd_addr,
   input  logic signed [VALUE_BITS-1:0] rd_data
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DISPATCH = 7'b0000010,
      S_SCAN     = 7'b0000100,
      S_SHIFT    = 7'b0001000,
      S_SORT     = 7'b0010000,
      S_FETCH    = 7'b0100000,
      S_FINISH   = 7'b1000000
   } state_type;

   state_type                       state_ff, state_in;
   logic [CW-1:0]                   occ_ff, occ_in;
   logic                            pend_ff, pend_in;
   logic [CW-1:0]                   ptr_ff, ptr_in;
   logic [AW-1:0]                   ppos_ff, ppos_in;
   logic [CW-1:0]                   lim_ff, lim_in;
   logic signed [VALUE_BITS-1:0]    carry_ff, carry_in;
   logic [svs_pkg::FUNC_W-1:0]      op_ff, op_in;
   logic signed [VALUE_BITS-1:0]    key_ff, key_in;
   logic [svs_pkg::INDEX_W-1:0]     idx_ff, idx_in;
   logic                            hit_ff, hit_in;
   logic [AW-1:0]                   hpos_ff, hpos_in;
   logic [svs_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic signed [svs_pkg::DATA_W-1:0] elem_ff, elem_in;

   logic match;
   logic idx_ok;

   assign match  = pend_ff && (rd_data == key_ff);
   assign idx_ok = {{CW{1'b0}}, idx_ff} < {{svs_pkg::INDEX_W{1'b0}}, occ_ff};

   always_comb begin
      state_in  = state_ff;
      occ_in    = occ_ff;
      pend_in   = 1'b0;
      ptr_in    = ptr_ff;
      ppos_in   = ppos_ff;
      lim_in    = lim_ff;
      carry_in  = carry_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      hit_in    = hit_ff;
      hpos_in   = hpos_ff;
      status_in = status_ff;
      elem_in   = elem_ff;
      wr_en     = 1'b0;
      wr_addr   = ppos_ff - AW'(1);
      wr_data   = rd_data;
      rd_addr   = ptr_ff[AW-1:0];
      req_ready = 1'b0;
      fin_valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_data.func;
               key_in    = VALUE_BITS'(req_data.value);
               idx_in    = req_data.index;
               hit_in    = 1'b0;
               hpos_in   = '0;
               status_in = svs_pkg::ST_OK;
               elem_in   = '0;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            ptr_in = '0;
            lim_in = occ_ff;
            case (op_ff)
               svs_pkg::OP_INSERT, svs_pkg::OP_REMOVE, svs_pkg::OP_QUERY: begin
                  state_in = S_SCAN;
               end
               svs_pkg::OP_CLEAR: begin
                  occ_in   = '0;
                  state_in = S_FINISH;
               end
               svs_pkg::OP_SORT: begin
                  state_in = (occ_ff < CW'(2)) ? S_FINISH : S_SORT;
               end
               svs_pkg::OP_READ: begin
                  rd_addr = AW'(idx_ff);
                  if (idx_ok) begin
                     state_in = S_FETCH;
                  end else begin
                     status_in = svs_pkg::ST_RANGE;
                     state_in  = S_FINISH;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SCAN: begin
            if (match) begin
               hit_in  = 1'b1;
               hpos_in = ppos_ff;
               if (op_ff == svs_pkg::OP_REMOVE) begin
                  ptr_in   = CW'(ppos_ff) + CW'(1);
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_FINISH;
               end
            end else if (ptr_ff == occ_ff) begin
               // every stored entry compared, value absent
               state_in = S_FINISH;
               if (op_ff == svs_pkg::OP_INSERT) begin
                  if (occ_ff < CW'(CAPACITY)) begin
                     wr_en   = 1'b1;
                     wr_addr = occ_ff[AW-1:0];
                     wr_data = key_ff;
                     occ_in  = occ_ff + CW'(1);
                  end else begin
                     status_in = svs_pkg::ST_FULL;
                  end
               end else begin
                  status_in = svs_pkg::ST_ABSENT;
               end
            end else begin
               pend_in = 1'b1;
               ppos_in = ptr_ff[AW-1:0];
               ptr_in  = ptr_ff + CW'(1);
            end
         end
         S_SHIFT: begin
            // entry p moves down to p-1 as it returns from the store
            wr_en = pend_ff;
            if (ptr_ff < occ_ff) begin
               pend_in = 1'b1;
               ppos_in = ptr_ff[AW-1:0];
               ptr_in  = ptr_ff + CW'(1);
            end else if (!pend_ff) begin
               occ_in   = occ_ff - CW'(1);
               state_in = S_FINISH;
            end
         end
         S_SORT: begin
            // carry holds the largest value seen so far in this pass
            if (pend_ff) begin
               if (ppos_ff == '0) begin
                  carry_in = rd_data;
               end else if (carry_ff > rd_data) begin
                  wr_en = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = carry_ff;
                  carry_in = rd_data;
               end
            end
            if (ptr_ff < lim_ff) begin
               pend_in = 1'b1;
               ppos_in = ptr_ff[AW-1:0];
               ptr_in  = ptr_ff + CW'(1);
            end else if (!pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(lim_ff - CW'(1));
               wr_data = carry_ff;
               lim_in  = lim_ff - CW'(1);
               ptr_in  = '0;
               if ((lim_ff - CW'(1)) < CW'(2)) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FETCH: begin
            elem_in  = svs_pkg::DATA_W'(rd_data);
            state_in = S_FINISH;
         end
         S_FINISH: begin
            fin_valid = 1'b1;
            if (fin_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      fin_data.status   = status_ff;
      fin_data.found    = hit_ff;
      fin_data.position = svs_pkg::POS_W'(hpos_ff);
      fin_data.count    = svs_pkg::COUNT_W'(occ_ff);
      fin_data.element  = elem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      ppos_ff   <= ppos_in;
      lim_ff    <= lim_in;
      carry_ff  <= carry_in;
      op_ff     <= op_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      hpos_ff   <= hpos_in;
      status_ff <= status_in;
      elem_ff   <= elem_in;
   end

endmodule

// File: rtl/small_value_set_engine.sv
// Value set engine: a set of up to CAPACITY distinct signed values held in
// one synchronous entry store. One item is worked on at a time; the next
// item is taken once the previous result sits in the output register, even
// while that result still waits for its transfer. With n the occupancy, query
// and insert read one store entry per compare, up to n entries; remove scans,
// then shifts each entry above the hit down, its read overlapping the write of
// the entry before it; clear and undefined codes touch no entry; read fetches
// one entry when the index is below the count; and sort, for n of two or more,
// runs bubble passes with one store access per compare in each pass. The
// single read port of the entry store allows one entry read at a time.
module small_value_set_engine #(
   parameter int CAPACITY   = svs_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = svs_pkg::VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  svs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output svs_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);

   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic signed [VALUE_BITS-1:0] wr_data;
   logic [AW-1:0]                rd_addr;
   logic signed [VALUE_BITS-1:0] rd_data;
   logic                         fin_valid;
   logic                         fin_take;
   svs_pkg::rsp_type             fin_data;

   logic             rsp_valid_ff, rsp_valid_in;
   svs_pkg::rsp_type rsp_data_ff;

   svs_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   svs_ctrl #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .fin_valid (fin_valid),
      .fin_take  (fin_take),
      .fin_data  (fin_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // output register: loads when empty or emptied by this cycle's transfer
   assign fin_take     = fin_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = fin_take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_take) begin
         rsp_data_ff <= fin_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/svs_checker.sv
// Port-level checks of the value set engine, bound to the top level.
// Depends on svs_pkg and small_value_set_engine_assert.svh.
`include "small_value_set_engine_assert.svh"

module svs_checker #(
   parameter int CAPACITY = svs_pkg::CAPACITY_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input svs_pkg::rsp_type rsp_data
);

   // a result waiting for its transfer stays offered
   `SVS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // one item at a time: ready drops right after an input transfer
   `SVS_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)

   `SVS_ASSERT_SAME(a_count_bound, clock, reset, rsp_valid,
                    {25'd0, rsp_data.count} <= CAPACITY)

   // position only carries data on a hit; element is zero when a read is out of range
   `SVS_ASSERT_SAME(a_miss_clean, clock, reset,
                    rsp_valid && (!rsp_data.found || rsp_data.status == svs_pkg::ST_RANGE),
                    rsp_data.position == '0 && (rsp_data.status != svs_pkg::ST_RANGE ||
                    rsp_data.element == '0))

endmodule

bind small_value_set_engine svs_checker #(
   .CAPACITY (CAPACITY)
) u_svs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
